>>> rtl/temperature_pi_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the temperature PI controller
// Shared concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_PI_CONTROLLER_MACROS_SVH
`define TEMPERATURE_PI_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define TPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature PI controller package
// Field widths, conversion constants, register indexes and shared types.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned TEMP_W     = 8;
  localparam int unsigned MV_W       = 11;
  localparam int unsigned ERR_W      = 9;
  localparam int unsigned GAIN_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // floor(5000 * s / 1023) == (s * MV_RECIP) >> MV_SHIFT for every 10-bit s.
  localparam int unsigned MV_RECIP_W = 24;
  localparam logic [MV_RECIP_W-1:0] MV_RECIP = 24'd10250010;
  localparam int unsigned MV_SHIFT   = 21;
  localparam int unsigned MV_PROD_W  = SAMPLE_W + MV_RECIP_W;
  localparam int unsigned MV_QUOT_W  = 13;
  localparam logic [MV_W-1:0] MV_LIMIT = 11'd1500;

  // floor(n / 10) == (n * DEG_RECIP) >> DEG_SHIFT for any n below 2^16.
  localparam int unsigned DEG_RECIP_W = 16;
  localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = 16'd52429;
  localparam int unsigned DEG_SHIFT   = 19;
  localparam int unsigned DEG_PROD_W  = MV_W + DEG_RECIP_W;

  localparam int unsigned SUM_W = 16;
  localparam logic signed [SUM_W-1:0] DRIVE_MAX  = 16'sd100;
  localparam logic [DUTY_W-1:0]       DRIVE_OVER = 7'd99;

  localparam logic [TEMP_W-1:0] TARGET_RESET = 8'd0;
  localparam logic [GAIN_W-1:0] IGAIN_RESET  = 4'd1;
  localparam logic [GAIN_W-1:0] PGAIN_RESET  = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_IGAIN  = 2'd1,
    CFG_PGAIN  = 2'd2
  } cfg_index_t;

  // Measurement handed from the conversion pipeline to the controller update.
  typedef struct packed {
    logic [MV_W-1:0]          mv;
    logic [TEMP_W-1:0]        temp;
    logic signed [ERR_W-1:0]  err;
  } meas_t;

  // Valid flag between the two pipeline halves; ready runs back separately.
  typedef struct packed {
    logic valid;
  } meas_ctl_t;

endpackage

>>> rtl/tpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature PI controller channel interfaces
// Sample input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpc_sample_if;
  logic                           valid;
  logic                           ready;
  logic [tpc_pkg::SAMPLE_W-1:0]   adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface tpc_result_if;
  logic                           valid;
  logic                           ready;
  logic [tpc_pkg::DUTY_W-1:0]     duty_percent;
  logic [tpc_pkg::TEMP_W-1:0]     measured_temperature;
  logic [tpc_pkg::MV_W-1:0]       millivolts;
  logic signed [tpc_pkg::ERR_W-1:0] control_error;

  modport source (output valid, output duty_percent, output measured_temperature,
                  output millivolts, output control_error, input ready);
  modport sink   (input valid, input duty_percent, input measured_temperature,
                  input millivolts, input control_error, output ready);
endinterface

>>> rtl/tpc_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature PI controller sample conversion
// Three-stage pipeline: sample register, millivolt register, temperature/error.
// ----------------------------------------------------------------------------
module tpc_convert (
  input  logic                          clk,
  input  logic                          rst,
  tpc_sample_if.sink                    sample,
  input  logic [tpc_pkg::TEMP_W-1:0]    target_temperature,
  output tpc_pkg::meas_ctl_t            meas_ctl,
  output tpc_pkg::meas_t                meas,
  input  logic                          meas_ready
);

  logic                               v0;
  logic [tpc_pkg::SAMPLE_W-1:0]       sample0;
  logic                               v1;
  logic [tpc_pkg::MV_W-1:0]           mv1;
  logic                               v2;
  tpc_pkg::meas_t                     meas2;

  logic                               rdy0;
  logic                               rdy1;
  logic                               rdy2;

  logic [tpc_pkg::MV_PROD_W-1:0]      mv_prod;
  logic [tpc_pkg::MV_QUOT_W-1:0]      mv_quot;
  logic [tpc_pkg::MV_W-1:0]           mv_next;
  logic [tpc_pkg::DEG_PROD_W-1:0]     deg_prod;
  logic [tpc_pkg::TEMP_W-1:0]         temp_next;
  logic [tpc_pkg::ERR_W:0]            err_wide;

  // A stage can load when it is empty or its content moves on this cycle.
  assign rdy2 = !v2 || meas_ready;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign sample.ready = rdy0;

  assign mv_prod = tpc_pkg::MV_PROD_W'(sample0) * tpc_pkg::MV_PROD_W'(tpc_pkg::MV_RECIP);
  assign mv_quot = mv_prod[tpc_pkg::MV_SHIFT +: tpc_pkg::MV_QUOT_W];
  assign mv_next = (mv_quot > tpc_pkg::MV_QUOT_W'(tpc_pkg::MV_LIMIT)) ?
                   tpc_pkg::MV_LIMIT : mv_quot[tpc_pkg::MV_W-1:0];

  assign deg_prod  = tpc_pkg::DEG_PROD_W'(mv1) * tpc_pkg::DEG_PROD_W'(tpc_pkg::DEG_RECIP);
  assign temp_next = deg_prod[tpc_pkg::DEG_SHIFT +: tpc_pkg::TEMP_W];
  // Target spans 0..255 and temperature 0..150, so the difference fits 9 bits signed.
  assign err_wide  = {2'b00, target_temperature} - {2'b00, temp_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= sample.valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && sample.valid) begin
      sample0 <= sample.adc_sample;
    end
    if (rdy1 && v0) begin
      mv1 <= mv_next;
    end
    if (rdy2 && v1) begin
      meas2.mv   <= mv1;
      meas2.temp <= temp_next;
      meas2.err  <= err_wide[tpc_pkg::ERR_W-1:0];
    end
  end

  assign meas_ctl.valid = v2;
  assign meas           = meas2;

endmodule

>>> rtl/tpc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature PI controller drive update
// Velocity-form PI step with clamping, controller state and result register.
// ----------------------------------------------------------------------------
module tpc_update (
  input  logic                          clk,
  input  logic                          rst,
  input  tpc_pkg::meas_ctl_t            meas_ctl,
  input  tpc_pkg::meas_t                meas,
  output logic                          meas_ready,
  input  logic [tpc_pkg::GAIN_W-1:0]    integral_gain,
  input  logic [tpc_pkg::GAIN_W-1:0]    proportional_gain,
  tpc_result_if.source                  result
);

  logic signed [tpc_pkg::ERR_W-1:0]     prev_err;
  logic [tpc_pkg::DUTY_W-1:0]           drive;
  logic                                 out_valid;

  logic                                 take;
  logic signed [tpc_pkg::ERR_W:0]       err_diff;
  logic signed [tpc_pkg::GAIN_W:0]      igain_s;
  logic signed [tpc_pkg::GAIN_W:0]      pgain_s;
  logic signed [tpc_pkg::GAIN_W+tpc_pkg::ERR_W:0]   i_term;
  logic signed [tpc_pkg::GAIN_W+tpc_pkg::ERR_W-1:0] p_term;
  logic signed [tpc_pkg::SUM_W-1:0]     sum;
  logic [tpc_pkg::DUTY_W-1:0]           drive_next;

  assign meas_ready = !out_valid || result.ready;
  assign take       = meas_ctl.valid && meas_ready;

  assign err_diff = {meas.err[tpc_pkg::ERR_W-1], meas.err} - {prev_err[tpc_pkg::ERR_W-1], prev_err};
  assign igain_s  = {1'b0, integral_gain};
  assign pgain_s  = {1'b0, proportional_gain};
  assign i_term   = igain_s * err_diff;
  assign p_term   = pgain_s * meas.err;

  // Worst case magnitude is about 10000, well inside 16 bits signed.
  assign sum = {{(tpc_pkg::SUM_W-tpc_pkg::DUTY_W){1'b0}}, drive}
             + {{(tpc_pkg::SUM_W-tpc_pkg::GAIN_W-tpc_pkg::ERR_W-1){i_term[$high(i_term)]}}, i_term}
             + {{(tpc_pkg::SUM_W-tpc_pkg::GAIN_W-tpc_pkg::ERR_W){p_term[$high(p_term)]}}, p_term};

  // Overshoot folds to 99 while exactly 100 is kept.
  always_comb begin
    if (sum[tpc_pkg::SUM_W-1]) begin
      drive_next = '0;
    end else if (sum > tpc_pkg::DRIVE_MAX) begin
      drive_next = tpc_pkg::DRIVE_OVER;
    end else begin
      drive_next = sum[tpc_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err  <= '0;
      drive     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        prev_err  <= meas.err;
        drive     <= drive_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.duty_percent         <= drive_next;
      result.measured_temperature <= meas.temp;
      result.millivolts           <= meas.mv;
      result.control_error        <= meas.err;
    end
  end

  assign result.valid = out_valid;

endmodule

>>> rtl/temperature_pi_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature PI controller
// Converts ADC samples to temperature and updates a PI drive value per sample.
// ----------------------------------------------------------------------------
// Usage: each word on the sample channel carries one 10-bit ADC reading. For
// every accepted word, exactly one word appears on the result channel with
// the new duty cycle, the measured temperature, the clamped millivolt value
// and the control error, in the order the samples arrived.
// Throughput is one sample per cycle while the receiver takes results. The
// sample register loads at the accepting edge, and the millivolt stage, the
// temperature/error stage and the result register (which also holds the PI
// state update) follow in that order before the result word is presented.
// The PI state (previous error and drive) lives next to the result register,
// so back-to-back samples see each other's updates with no extra wait.
// When the receiver stalls, the result word holds and the pipeline stages
// behind it keep filling; sample ready drops once all four registers are full.
// Synchronous reset empties the pipeline, clears the drive and previous
// error, and returns target 0, integral gain 1 and proportional gain 2.
// The configuration port writes one register per cycle with no read-back;
// it is to be used only while no sample is in flight.
// ----------------------------------------------------------------------------
module temperature_pi_controller (
  input  logic                              clk,
  input  logic                              rst,
  tpc_sample_if.sink                        sample,
  tpc_result_if.source                      result,
  input  logic                              cfg_write,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [tpc_pkg::TEMP_W-1:0]  target_temperature;
  logic [tpc_pkg::GAIN_W-1:0]  integral_gain;
  logic [tpc_pkg::GAIN_W-1:0]  proportional_gain;

  // Link between the conversion pipeline and the drive update.
  tpc_pkg::meas_ctl_t          meas_ctl;
  tpc_pkg::meas_t              meas;
  logic                        meas_ready;

  // Writes to an index outside the register list fall to the default arm
  // and change nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_temperature <= tpc_pkg::TARGET_RESET;
      integral_gain      <= tpc_pkg::IGAIN_RESET;
      proportional_gain  <= tpc_pkg::PGAIN_RESET;
    end else if (cfg_write) begin
      unique case (tpc_pkg::cfg_index_t'(cfg_index))
        tpc_pkg::CFG_TARGET: begin
          target_temperature <= cfg_data[tpc_pkg::TEMP_W-1:0];
        end
        tpc_pkg::CFG_IGAIN: begin
          integral_gain <= cfg_data[tpc_pkg::GAIN_W-1:0];
        end
        tpc_pkg::CFG_PGAIN: begin
          proportional_gain <= cfg_data[tpc_pkg::GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Sample to millivolts to degrees, and the error against the target.
  tpc_convert u_convert (
    .clk                (clk),
    .rst                (rst),
    .sample             (sample),
    .target_temperature (target_temperature),
    .meas_ctl           (meas_ctl),
    .meas               (meas),
    .meas_ready         (meas_ready)
  );

  // Velocity-form PI step, clamping and the result register.
  tpc_update u_update (
    .clk               (clk),
    .rst               (rst),
    .meas_ctl          (meas_ctl),
    .meas              (meas),
    .meas_ready        (meas_ready),
    .integral_gain     (integral_gain),
    .proportional_gain (proportional_gain),
    .result            (result)
  );

endmodule

>>> rtl/tpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature PI controller port checker
// Assertions on the result channel as seen from the top-level ports.
// ----------------------------------------------------------------------------
`include "temperature_pi_controller_macros.svh"

module tpc_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  logic [tpc_pkg::DUTY_W-1:0]    duty_percent,
  input  logic [tpc_pkg::TEMP_W-1:0]    measured_temperature,
  input  logic [tpc_pkg::MV_W-1:0]      millivolts
);

  logic [tpc_pkg::MV_W+3:0] temp_x10;

  assign temp_x10 = {measured_temperature, 3'b000} + {2'b00, measured_temperature, 1'b0};

  `TPC_ASSERT_SAME(a_duty_range, result_valid, duty_percent <= 7'd100, "duty above 100")
  `TPC_ASSERT_SAME(a_temp_matches_mv,
    result_valid,
    (millivolts <= tpc_pkg::MV_LIMIT) && (temp_x10 <= 15'(millivolts)) &&
    (15'(millivolts) < temp_x10 + 15'd10),
    "temperature is not millivolts over ten")
  `TPC_ASSERT_NEXT(a_stall_holds,
    result_valid && !result_ready,
    result_valid && $stable(duty_percent) && $stable(millivolts),
    "stalled result word changed")
  `TPC_ASSERT_SAME(a_empty_after_reset, $past(rst), !result_valid, "result valid after reset")

endmodule

bind temperature_pi_controller tpc_checker u_tpc_checker (
  .clk                  (clk),
  .rst                  (rst),
  .result_valid         (result.valid),
  .result_ready         (result.ready),
  .duty_percent         (result.duty_percent),
  .measured_temperature (result.measured_temperature),
  .millivolts           (result.millivolts)
);

>>> tb/sv/tb_temperature_pi_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the temperature PI controller
// Sends ADC samples under several register settings and idle patterns. A
// local model of the conversion and the velocity-form PI update predicts
// every result word, and a checker compares each field as the word arrives.
// ----------------------------------------------------------------------------
module tb_temperature_pi_controller;
  import tpc_pkg::*;

  // Conversion constants: 0..1023 spans 0..5000 mV, and 10 mV is one degree.
  localparam int MV_FULL_SCALE  = 5000;
  localparam int ADC_FULL_SCALE = 1023;
  localparam int MV_PER_DEGREE  = 10;

  // Samples above about 307 all clamp to 1500 mV, so most random samples stay
  // below this span to keep the measured temperature moving.
  localparam int SAMPLE_LIVE_SPAN = 310;

  // Register index 3 exists on the port but names no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // After the last result word arrives, the bench waits out SETTLE_CYCLES
  // before the block counts as idle.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 109;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    logic [TEMP_W-1:0]       temp;
    logic [MV_W-1:0]         mv;
    logic signed [ERR_W-1:0] err;
  } reading_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tpc_sample_if smp ();
  tpc_result_if res ();

  temperature_pi_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .result    (res),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the registers and the controller state.
  logic [TEMP_W-1:0] target_q;
  logic [GAIN_W-1:0] igain_q;
  logic [GAIN_W-1:0] pgain_q;
  int                prev_err_q;
  int                drive_q;

  // Predicted result words, oldest first.
  reading_t pending_readings[$];

  int error_count = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  // Last random sample, used as the center of the random walk.
  logic [SAMPLE_W-1:0] walk_sample = '0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a run that never drains ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[temperature_pi_controller] ERROR");
      $finish;
    end
  end

  // The receiver stalls in stall_pct cycles out of a hundred.
  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Predicts one result word and advances the local PI state. The drive sum is
  // taken at full integer width, then clamped: above 100 falls back to 99,
  // exactly 100 stays, and a negative sum becomes 0.
  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] s);
    int       mv;
    int       deg;
    int       err;
    int       next_drive;
    reading_t r;
    mv = (MV_FULL_SCALE * int'(s)) / ADC_FULL_SCALE;
    if (mv > int'(MV_LIMIT)) begin
      mv = int'(MV_LIMIT);
    end
    deg = mv / MV_PER_DEGREE;
    err = int'(target_q) - deg;
    next_drive = drive_q + int'(igain_q) * (err - prev_err_q) + int'(pgain_q) * err;
    if (next_drive > int'(DRIVE_MAX)) begin
      next_drive = int'(DRIVE_OVER);
    end
    if (next_drive < 0) begin
      next_drive = 0;
    end
    prev_err_q = err;
    drive_q    = next_drive;
    r.duty = next_drive[DUTY_W-1:0];
    r.temp = deg[TEMP_W-1:0];
    r.mv   = mv[MV_W-1:0];
    r.err  = err[ERR_W-1:0];
    return r;
  endfunction

  // Each accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin : check_result
    reading_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_readings.size() == 0) begin
        $error("result word with no sample pending");
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        if (res.duty_percent !== want.duty) begin
          $error("duty_percent: expected %0d, actual %0d", want.duty, res.duty_percent);
          error_count++;
        end
        if (res.measured_temperature !== want.temp) begin
          $error("measured_temperature: expected %0d, actual %0d",
                 want.temp, res.measured_temperature);
          error_count++;
        end
        if (res.millivolts !== want.mv) begin
          $error("millivolts: expected %0d, actual %0d", want.mv, res.millivolts);
          error_count++;
        end
        if (res.control_error !== want.err) begin
          $error("control_error: expected %0d, actual %0d",
                 want.err, $signed(res.control_error));
          error_count++;
        end
      end
    end
  end

  // Sends one sample word. Valid stays high from one word to the next unless
  // the sender goes idle, so it is never lowered and raised in one step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if ($urandom_range(99) < idle_pct) begin
      smp.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    smp.valid      <= 1'b1;
    smp.adc_sample <= s;
    do @(posedge clk); while (!smp.ready);
    pending_readings.push_back(predict_reading(s));
  endtask

  // Lets every pending result word arrive, then gives the pipeline time to
  // empty before anything touches the registers.
  task automatic wait_idle();
    smp.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. The enable is left high so back-to-back writes do not
  // toggle it; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_TARGET: target_q = data;
      CFG_IGAIN:  igain_q  = data[GAIN_W-1:0];
      CFG_PGAIN:  pgain_q  = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all three registers. The unused upper bits of the gain words carry
  // random junk, which the block must drop.
  task automatic configure(input logic [TEMP_W-1:0] t, input logic [GAIN_W-1:0] ig,
                           input logic [GAIN_W-1:0] pg);
    logic [CFG_DATA_W-GAIN_W-1:0] junk_i;
    logic [CFG_DATA_W-GAIN_W-1:0] junk_p;
    junk_i = $urandom;
    junk_p = $urandom;
    write_reg(CFG_TARGET, t);
    write_reg(CFG_IGAIN, {junk_i, ig});
    write_reg(CFG_PGAIN, {junk_p, pg});
    cfg_write <= 1'b0;
  endtask

  // Random sample: part random walk, so the loop can settle near the target,
  // part spread over the live span, part anywhere in the full range.
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 40) begin
      v = int'(walk_sample) + int'($urandom_range(16)) - 8;
      if (v < 0) begin
        v = 0;
      end
      if (v > ADC_FULL_SCALE) begin
        v = ADC_FULL_SCALE;
      end
    end else if (pick < 75) begin
      v = $urandom_range(SAMPLE_LIVE_SPAN);
    end else begin
      v = $urandom_range(ADC_FULL_SCALE);
    end
    walk_sample = v[SAMPLE_W-1:0];
    return walk_sample;
  endfunction

  // Registers as they come out of reset: target 0, gains 1 and 2. The samples
  // cover both ends of the range and the point where the millivolt clamp starts.
  task automatic test_reset_defaults();
    send_sample('0);
    send_sample(SAMPLE_W'(ADC_FULL_SCALE));
    send_sample(SAMPLE_W'(306));
    send_sample(SAMPLE_W'(307));
    wait_idle();
  endtask

  // Walks the drive into each clamp: a sum of exactly 100 is kept, the next sum
  // of 200 falls back to 99, and a large negative error pulls it down to zero.
  task automatic test_drive_limits();
    configure(8'd100, 4'd0, 4'd1);
    send_sample('0);
    send_sample('0);
    wait_idle();
    configure(8'd0, 4'd0, 4'd1);
    send_sample(SAMPLE_W'(ADC_FULL_SCALE));
    wait_idle();
  endtask

  // Largest target and gains, with samples that swing the error end to end so
  // the full-width sum reaches its largest magnitudes.
  task automatic test_gain_extremes();
    configure(8'd255, 4'd15, 4'd15);
    send_sample('0);
    send_sample(SAMPLE_W'(ADC_FULL_SCALE));
    send_sample(SAMPLE_W'(512));
    send_sample(SAMPLE_W'(205));
    send_sample(SAMPLE_W'(1));
    wait_idle();
  endtask

  // Writes to the unused index must leave every register alone, and only the
  // low four bits of a gain word count.
  task automatic test_register_decode();
    write_reg(CFG_UNUSED, 8'hA5);
    write_reg(CFG_IGAIN, 8'hF3);
    write_reg(CFG_PGAIN, 8'h5C);
    write_reg(CFG_TARGET, 8'd150);
    write_reg(CFG_UNUSED, 8'h5A);
    cfg_write <= 1'b0;
    send_sample(SAMPLE_W'(100));
    send_sample(SAMPLE_W'(250));
    send_sample(SAMPLE_W'(300));
    wait_idle();
  endtask

  // One phase of random samples under a given setting and idle pattern.
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input logic [TEMP_W-1:0] t, input logic [GAIN_W-1:0] ig,
                                     input logic [GAIN_W-1:0] pg);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    configure(t, ig, pg);
    // Start the walk near the sample that reads the target temperature.
    walk_sample = (t > 8'd150) ? SAMPLE_W'(307) : SAMPLE_W'(int'(t) * 2);
    repeat (PHASE_ITEMS) send_sample(next_sample());
    wait_idle();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_write      <= 1'b0;
    cfg_index      <= CFG_TARGET;
    cfg_data       <= '0;
    smp.valid      <= 1'b0;
    smp.adc_sample <= '0;
    target_q   = TARGET_RESET;
    igain_q    = IGAIN_RESET;
    pgain_q    = PGAIN_RESET;
    prev_err_q = 0;
    drive_q    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_drive_limits();
    test_gain_extremes();
    test_register_decode();

    // Random phases: no idling, sender idle, receiver stalling, then both.
    test_random_traffic(0, 0, 8'd0, 4'd0, 4'd0);
    test_random_traffic(47, 0, 8'd255, 4'd15, 4'd15);
    test_random_traffic(0, 47, TEMP_W'($urandom_range(150)), GAIN_W'($urandom),
                        GAIN_W'($urandom));
    test_random_traffic(21, 21, TEMP_W'($urandom_range(255)), GAIN_W'($urandom),
                        GAIN_W'($urandom));

    if (error_count == 0) begin
      $display("[temperature_pi_controller] OK");
    end else begin
      $display("[temperature_pi_controller] ERROR");
    end
    $finish;
  end

endmodule
